// ----- src/particle_square_splat_macros.svh -----
// Assertion macros shared by the splat block.
`ifndef PARTICLE_SQUARE_SPLAT_MACROS_SVH
`define PARTICLE_SQUARE_SPLAT_MACROS_SVH

// same-cycle implication
`define PSS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/pss_pkg.sv -----
// Package: widths, word types, register codes and state types of the splat block.
`timescale 1ns / 1ps
package pss_pkg;

    localparam int MAX_DIM     = 4096;
    localparam int MAX_RADIUS  = 3;
    localparam int COORD_W     = $clog2(MAX_DIM);
    localparam int DIM_W       = COORD_W + 1;
    localparam int RAD_W       = 2;
    localparam int EXT_W       = 16;
    localparam int FRAC_W      = 16;
    localparam int POS_W       = 32;
    localparam int MAG_W       = 32;
    localparam int DEN_W       = EXT_W + FRAC_W;
    localparam int PROD_W      = COORD_W + MAG_W;
    localparam int PIX_W       = 24;
    localparam int COLOUR_W    = 24;
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_XEXT   = 3'd2,
        CFG_YEXT   = 3'd3,
        CFG_RADIUS = 3'd4,
        CFG_LIGHT  = 3'd5,
        CFG_MEDIUM = 3'd6,
        CFG_HEAVY  = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PT_LIGHT   = 2'd0,
        PT_MEDIUM  = 2'd1,
        PT_HEAVY   = 2'd2,
        PT_UNKNOWN = 2'd3
    } t_ptype;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        t_ptype                  particle_type;
    } t_in_word;

    typedef struct packed {
        logic              write_valid;
        logic [PIX_W-1:0]  pixel_index;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic              in_range;
        logic              last;
    } t_out_word;

    // saturated configuration as seen by front and back
    typedef struct packed {
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
        logic [EXT_W-1:0]    x_ext;
        logic [EXT_W-1:0]    y_ext;
        logic [RAD_W-1:0]    radius;
        logic [COLOUR_W-1:0] light;
        logic [COLOUR_W-1:0] med;
        logic [COLOUR_W-1:0] heavy;
    } t_cfg;

    typedef struct packed {
        logic                in_range;
        logic [COORD_W-1:0]  col;
        logic [COORD_W-1:0]  row;
        logic [COLOUR_W-1:0] colour;
    } t_job;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_MUL,
        FS_DIV,
        FS_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_BASE,
        BS_EMIT
    } t_back_state;

endpackage

// ----- src/pss_div.sv -----
// Restoring divider, one quotient bit per cycle, for the coordinate mapping.
`timescale 1ns / 1ps
module pss_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pss_pkg::PROD_W-1:0]   i_num,
    input  logic [pss_pkg::DEN_W-1:0]    i_den,
    output logic                         o_done,
    output logic [pss_pkg::COORD_W-1:0]  o_quot
);
    import pss_pkg::*;

    localparam int CNT_W = $clog2(COORD_W);

    logic [DEN_W-1:0]   r_rem;
    logic [DEN_W-1:0]   r_den;
    logic [COORD_W-1:0] r_low;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    // caller guarantees quotient < 2**COORD_W, so the top part starts below den
    assign trial = {r_rem, r_low[COORD_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(COORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[PROD_W-1:COORD_W];
            r_low <= i_num[COORD_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_low <= {r_low[COORD_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_low;

endmodule

// ----- src/pss_queue.sv -----
// Short job queue between the mapping front and the write back.
`timescale 1ns / 1ps
`include "particle_square_splat_macros.svh"
module pss_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pss_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output pss_pkg::t_job o_job
);
    import pss_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    logic [PTR_W-1:0] n_wp;
    logic [PTR_W-1:0] n_rp;

    assign n_wp = (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_rp = (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    `PSS_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full || i_pop, "push into full queue")
    `PSS_ASSERT_NXT(a_fill_count, i_clk, i_rst_n, i_push && !i_pop, r_cnt == $past(r_cnt) + 1'b1, "queue fill count did not advance")

endmodule

// ----- src/pss_front.sv -----
// Front: takes particles, maps both coordinates and classifies them into jobs.
`timescale 1ns / 1ps
`include "particle_square_splat_macros.svh"
module pss_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pss_pkg::t_cfg     i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pss_pkg::t_in_word i_in_word,
    output logic              o_push,
    output pss_pkg::t_job     o_job,
    input  logic              i_full
);
    import pss_pkg::*;

    t_front_state       r_state;
    t_front_state       n_state;
    t_in_word           r_word;
    logic               r_sel;
    logic               r_off;
    logic [COORD_W-1:0] r_col;
    logic [COORD_W-1:0] r_row;

    logic [POS_W-1:0]       raw;
    logic                   neg;
    logic [MAG_W-1:0]       mag;
    logic [DIM_W-1:0]       dim;
    logic [EXT_W-1:0]       ext;
    logic [DEN_W-1:0]       den;
    logic [DIM_W+MAG_W-1:0] prod_full;
    logic                   bad_now;
    logic                   div_start;
    logic                   div_done;
    logic [COORD_W-1:0]     div_quot;
    logic                   accept;
    logic [COLOUR_W-1:0]    colour;

    assign raw       = r_sel ? r_word.pos_y : r_word.pos_x;
    assign neg       = raw[POS_W-1];
    assign mag       = neg ? MAG_W'(~raw + 1'b1) : MAG_W'(raw);
    assign dim       = r_sel ? i_cfg.height : i_cfg.width;
    assign ext       = r_sel ? i_cfg.y_ext : i_cfg.x_ext;
    assign den       = {ext, {FRAC_W{1'b0}}};
    assign prod_full = dim * mag;
    // dim*mag >= dim*den exactly when mag >= den
    assign bad_now   = (dim == '0) || (ext == '0) || (mag >= den);

    pss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (prod_full[PROD_W-1:0]),
        .i_den   (den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        div_start  = 1'b0;
        o_push     = 1'b0;
        unique case (r_state)
            FS_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = FS_MUL;
                end
            end
            FS_MUL: begin
                if (bad_now) begin
                    n_state = FS_PUSH;
                end else begin
                    div_start = 1'b1;
                    n_state   = FS_DIV;
                end
            end
            FS_DIV: begin
                if (div_done) begin
                    if ((neg && div_quot != '0) || r_sel) begin
                        n_state = FS_PUSH;
                    end else begin
                        n_state = FS_MUL;
                    end
                end
            end
            FS_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = FS_IDLE;
                end
            end
        endcase
    end

    assign accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= i_in_word;
            r_sel  <= 1'b0;
            r_off  <= 1'b0;
        end else if (r_state == FS_MUL && bad_now) begin
            r_off <= 1'b1;
        end else if (r_state == FS_DIV && div_done) begin
            if (neg && div_quot != '0) begin
                r_off <= 1'b1;
            end
            if (!r_sel) begin
                r_col <= div_quot;
                r_sel <= 1'b1;
            end else begin
                r_row <= div_quot;
            end
        end
    end

    always_comb begin
        unique case (r_word.particle_type)
            PT_LIGHT:   colour = i_cfg.light;
            PT_MEDIUM:  colour = i_cfg.med;
            PT_HEAVY:   colour = i_cfg.heavy;
            PT_UNKNOWN: colour = '0;
        endcase
    end

    assign o_job = '{in_range: !r_off, col: r_col, row: r_row, colour: colour};

    `PSS_ASSERT_IMP(a_div_done_in_div, i_clk, i_rst_n, div_done, r_state == FS_DIV, "divider finished outside divide state")

endmodule

// ----- src/pss_back.sv -----
// Back: walks the clipped square of each job and emits pixel write words.
`timescale 1ns / 1ps
`include "particle_square_splat_macros.svh"
module pss_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pss_pkg::t_cfg      i_cfg,
    input  logic               i_empty,
    input  pss_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pss_pkg::t_out_word o_out_word
);
    import pss_pkg::*;

    t_back_state         r_state;
    t_back_state         n_state;
    logic                r_inr;
    logic [COLOUR_W-1:0] r_colour;
    logic [COORD_W-1:0]  r_c0;
    logic [COORD_W-1:0]  r_c1;
    logic [COORD_W-1:0]  r_r0;
    logic [COORD_W-1:0]  r_r1;
    logic [COORD_W-1:0]  r_c;
    logic [COORD_W-1:0]  r_r;
    logic [PIX_W-1:0]    r_idx;
    logic [PIX_W-1:0]    r_row_start;
    logic                r_ov;
    t_out_word           r_out;

    logic [DIM_W-1:0]         col_hi;
    logic [DIM_W-1:0]         row_hi;
    logic [COORD_W-1:0]       c0;
    logic [COORD_W-1:0]       c1;
    logic [COORD_W-1:0]       r0;
    logic [COORD_W-1:0]       r1;
    logic [COORD_W+DIM_W-1:0] base_full;
    logic [PIX_W-1:0]         next_row;
    logic                     row_end;
    logic                     fin;
    logic                     out_free;
    logic                     emit;
    t_out_word                word;

    assign col_hi = DIM_W'(i_job.col) + DIM_W'(i_cfg.radius);
    assign row_hi = DIM_W'(i_job.row) + DIM_W'(i_cfg.radius);
    assign c0 = (i_job.col < COORD_W'(i_cfg.radius)) ? '0 : i_job.col - COORD_W'(i_cfg.radius);
    assign r0 = (i_job.row < COORD_W'(i_cfg.radius)) ? '0 : i_job.row - COORD_W'(i_cfg.radius);
    assign c1 = (col_hi >= i_cfg.width) ? COORD_W'(i_cfg.width - 1'b1) : COORD_W'(col_hi);
    assign r1 = (row_hi >= i_cfg.height) ? COORD_W'(i_cfg.height - 1'b1) : COORD_W'(row_hi);

    assign base_full = r_r0 * i_cfg.width;
    assign next_row  = r_row_start + PIX_W'(i_cfg.width);
    assign row_end   = (r_c == r_c1);
    assign fin       = row_end && (r_r == r_r1);
    assign out_free  = !r_ov || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        emit    = 1'b0;
        unique case (r_state)
            BS_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = i_job.in_range ? BS_BASE : BS_EMIT;
                end
            end
            BS_BASE: begin
                n_state = BS_EMIT;
            end
            BS_EMIT: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (!r_inr || fin) begin
                        n_state = BS_IDLE;
                    end
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_inr    <= i_job.in_range;
            r_colour <= i_job.colour;
            r_c0     <= c0;
            r_c1     <= c1;
            r_r0     <= r0;
            r_r1     <= r1;
            r_c      <= c0;
            r_r      <= r0;
        end else if (r_state == BS_BASE) begin
            r_idx       <= PIX_W'(base_full) + PIX_W'(r_c0);
            r_row_start <= PIX_W'(base_full) + PIX_W'(r_c0);
        end else if (emit && r_inr) begin
            if (row_end) begin
                r_c         <= r_c0;
                r_r         <= r_r + 1'b1;
                r_row_start <= next_row;
                r_idx       <= next_row;
            end else begin
                r_c   <= r_c + 1'b1;
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_comb begin
        word             = '0;
        word.last        = 1'b1;
        if (r_inr) begin
            word.write_valid = 1'b1;
            word.pixel_index = r_idx;
            word.red         = r_colour[3*BYTE_W-1:2*BYTE_W];
            word.green       = r_colour[2*BYTE_W-1:BYTE_W];
            word.blue        = r_colour[BYTE_W-1:0];
            word.in_range    = 1'b1;
            word.last        = fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= word;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;

    `PSS_ASSERT_IMP(a_walk_in_box, i_clk, i_rst_n, r_state == BS_EMIT && r_inr, r_r <= r_r1 && r_c <= r_c1 && r_c >= r_c0, "square walk left its box")
    `PSS_ASSERT_IMP(a_off_word, i_clk, i_rst_n, r_ov && !r_out.in_range, r_out.last && !r_out.write_valid, "off-image word not a lone marked non-write")

endmodule

// ----- src/particle_square_splat.sv -----
// Top level: configuration registers, mapping front, job queue and write back.
//
//  channel   direction  handshake                 word
//  in        input      i_in_valid / o_in_stall    t_in_word: pos_x, pos_y, particle_type
//  out       output     o_out_valid / i_out_stall  t_out_word: one pixel write or off-image mark
//  cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  Front: one serial divider, shared by both coordinates, maps each particle; the front takes
//  no new particle until its job is pushed. Back: it pops a job, forms its base index, then
//  emits one write word per pixel of the clipped square (at most 7x7) or one off-image mark.
//  Reset is synchronous, active low; it empties the queue and loads the register defaults.
//  An output stall holds the back only; the front keeps mapping until the queue fills.
`timescale 1ns / 1ps
module particle_square_splat (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  pss_pkg::t_in_word                  i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output pss_pkg::t_out_word                 o_out_word,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pss_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pss_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import pss_pkg::*;

    logic [DIM_W-1:0]    r_width;
    logic [DIM_W-1:0]    r_height;
    logic [EXT_W-1:0]    r_x_ext;
    logic [EXT_W-1:0]    r_y_ext;
    logic [RAD_W-1:0]    r_radius;
    logic [COLOUR_W-1:0] r_light;
    logic [COLOUR_W-1:0] r_medium;
    logic [COLOUR_W-1:0] r_heavy;

    t_cfg cfg;
    t_job push_job;
    t_job pop_job;
    logic push;
    logic pop;
    logic full;
    logic empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(1024);
            r_height <= DIM_W'(1024);
            r_x_ext  <= EXT_W'(1);
            r_y_ext  <= EXT_W'(1);
            r_radius <= RAD_W'(1);
            r_light  <= '0;
            r_medium <= '0;
            r_heavy  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                CFG_XEXT:   r_x_ext  <= i_cfg_data[EXT_W-1:0];
                CFG_YEXT:   r_y_ext  <= i_cfg_data[EXT_W-1:0];
                CFG_RADIUS: r_radius <= i_cfg_data[RAD_W-1:0];
                CFG_LIGHT:  r_light  <= i_cfg_data[COLOUR_W-1:0];
                CFG_MEDIUM: r_medium <= i_cfg_data[COLOUR_W-1:0];
                CFG_HEAVY:  r_heavy  <= i_cfg_data[COLOUR_W-1:0];
            endcase
        end
    end

    always_comb begin
        cfg        = '0;
        cfg.width  = (r_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_width;
        cfg.height = (r_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_height;
        cfg.x_ext  = r_x_ext;
        cfg.y_ext  = r_y_ext;
        cfg.radius = (r_radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : r_radius;
        cfg.light  = r_light;
        cfg.med    = r_medium;
        cfg.heavy  = r_heavy;
    end

    pss_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_push     (push),
        .o_job      (push_job),
        .i_full     (full)
    );

    pss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (pop_job)
    );

    pss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_empty     (empty),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule
